### sv/mss_pkg.sv
// ----------------------------------------------------------------------------
// mss_pkg: shared types and constants of the seven-segment scanner.
// Holds the word types of both channels, the command codes, the clamp limits,
// the link between the converter and the scan unit, and the segment decoder.
// ----------------------------------------------------------------------------
package mss_pkg;

  localparam int unsigned ValWidth    = 7;
  localparam int unsigned CtrWidth    = 20;
  localparam int unsigned CtrDigits   = 6;
  localparam int unsigned SlotCount   = 9;
  localparam int unsigned SlotWidth   = 4;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  localparam logic [ValWidth-1:0] VAL_MAX = 7'd99;
  localparam logic [CtrWidth-1:0] CTR_MAX = 20'd999999;

  localparam logic [3:0] BLANK_CODE = 4'd10;

  localparam logic [SlotWidth-1:0] SLOT_LAST = 4'd8;

  typedef struct packed {
    logic                command;
    logic [ValWidth-1:0] two_digit_value;
    logic [CtrWidth-1:0] counter_value;
  } in_word_t;

  typedef struct packed {
    logic [2:0] select_code;
    logic       high_bank;
    logic [7:0] segment_pattern;
  } out_word_t;

  // Converter status and finished digits, handed to the scan unit.
  typedef struct packed {
    logic                     busy;
    logic                     wr;
    logic [3:0]               val_tens;
    logic [3:0]               val_units;
    logic [CtrDigits-1:0][3:0] ctr_digits;
  } bcd_result_t;

  // Segment decoder, segments a..g in bits 0..6, decimal point off.
  function automatic logic [7:0] seg_pattern(input logic [3:0] code);
    logic [7:0] pat;
    case (code)
      4'd0:    pat = 8'h3F;
      4'd1:    pat = 8'h06;
      4'd2:    pat = 8'h5B;
      4'd3:    pat = 8'h4F;
      4'd4:    pat = 8'h66;
      4'd5:    pat = 8'h6D;
      4'd6:    pat = 8'h7D;
      4'd7:    pat = 8'h07;
      4'd8:    pat = 8'h7F;
      4'd9:    pat = 8'h6F;
      default: pat = 8'h00;
    endcase
    return pat;
  endfunction

  // Double-dabble correction of one decimal digit.
  function automatic logic [3:0] add3(input logic [3:0] d);
    logic [3:0] r;
    r = (d >= 4'd5) ? d + 4'd3 : d;
    return r;
  endfunction

endpackage

### sv/multiplexed_seven_segment_scanner_top.sv
// ----------------------------------------------------------------------------
// multiplexed_seven_segment_scanner_top: nine-digit display scanner.
// Converts loaded values to decimal digits and drives one slot per tick.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one word per handshake. A word with the load
//   command clamps the two-digit value to 99 and the counter to 999999 and
//   converts both to decimal digits; it produces no output word. A word with
//   the tick command produces one output word for the current scan slot
//   (select code, high-bank enable and segment pattern) and moves to the
//   next slot, wrapping from slot 8 back to slot 0. Slot 2 is always blank.
//   A tick's word is valid on the output from the next cycle. A load runs
//   through the accepting step, 20 bit-serial shift steps over the counter
//   bits and a final step that writes the digit store. Input stall is high
//   while a load is converting.
//   After reset every digit shows blank, the scan slot is 0 and no output
//   word is pending. When the receiver stalls, the output word holds and a
//   new word is taken only once the waiting word leaves.
// ----------------------------------------------------------------------------
module multiplexed_seven_segment_scanner_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  mss_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output mss_pkg::out_word_t out_word_o
);
  import mss_pkg::*;

  bcd_result_t bcd_result;
  logic        in_accept;
  logic        load_start;
  logic        tick;

  // Hold off new words while the converter runs or while an output word is
  // waiting on a stalled receiver. A word leaving this cycle frees the slot.
  assign in_stall_o = bcd_result.busy | (out_valid_o & out_stall_i);
  assign in_accept  = in_valid_i & ~in_stall_o;
  assign load_start = in_accept & (in_word_i.command == CMD_LOAD);
  assign tick       = in_accept & (in_word_i.command == CMD_TICK);

  mss_bcd u_bcd (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (load_start),
    .value_i   (in_word_i.two_digit_value),
    .counter_i (in_word_i.counter_value),
    .result_o  (bcd_result)
  );

  mss_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tick_i      (tick),
    .load_i      (bcd_result),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o)
  );

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bcd_result.busy |-> !in_accept)
    else $error("word accepted during conversion");

  a_load_starts_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_start |=> bcd_result.busy)
    else $error("load did not start the converter");

  a_tick_gives_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick |=> out_valid_o)
    else $error("tick produced no output word");

endmodule

### sv/mss_bcd.sv
// ----------------------------------------------------------------------------
// mss_bcd: bit-serial binary to decimal converter.
// Clamps both values, then shifts one binary bit per cycle into the decimal
// digit registers with the add-three correction, twenty steps in all.
// ----------------------------------------------------------------------------
module mss_bcd (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [mss_pkg::ValWidth-1:0] value_i,
  input  logic [mss_pkg::CtrWidth-1:0] counter_i,
  output mss_pkg::bcd_result_t      result_o
);
  import mss_pkg::*;

  localparam int unsigned CntWidth = $clog2(CtrWidth);
  localparam logic [CntWidth-1:0] CntLast  = CntWidth'(CtrWidth - 1);
  localparam logic [CntWidth-1:0] ValStart = CntWidth'(CtrWidth - ValWidth);

  typedef enum logic [2:0] {
    BcdIdle  = 3'b001,
    BcdShift = 3'b010,
    BcdDone  = 3'b100
  } bcd_state_e;

  bcd_state_e state_q, state_d;
  logic [CntWidth-1:0]     cnt_q, cnt_d;
  logic [CtrWidth-1:0]     bin_q, bin_d;
  logic [ValWidth-1:0]     val_q, val_d;
  logic [CtrDigits*4-1:0]  ctr_bcd_q, ctr_bcd_d;
  logic [7:0]              val_bcd_q, val_bcd_d;
  logic [CtrDigits*4-1:0]  ctr_adj;
  logic [7:0]              val_adj;

  always_comb begin
    for (int i = 0; i < CtrDigits; i++) begin
      ctr_adj[i*4 +: 4] = add3(ctr_bcd_q[i*4 +: 4]);
    end
    for (int i = 0; i < 2; i++) begin
      val_adj[i*4 +: 4] = add3(val_bcd_q[i*4 +: 4]);
    end
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    bin_d     = bin_q;
    val_d     = val_q;
    ctr_bcd_d = ctr_bcd_q;
    val_bcd_d = val_bcd_q;
    case (state_q)
      BcdIdle: begin
        if (start_i) begin
          bin_d     = (counter_i > CTR_MAX) ? CTR_MAX : counter_i;
          val_d     = (value_i > VAL_MAX) ? VAL_MAX : value_i;
          ctr_bcd_d = '0;
          val_bcd_d = '0;
          cnt_d     = '0;
          state_d   = BcdShift;
        end
      end
      BcdShift: begin
        ctr_bcd_d = {ctr_adj[CtrDigits*4-2:0], bin_q[CtrWidth-1]};
        bin_d     = {bin_q[CtrWidth-2:0], 1'b0};
        // The short value enters late so that both finish on the same step.
        if (cnt_q >= ValStart) begin
          val_bcd_d = {val_adj[6:0], val_q[ValWidth-1]};
          val_d     = {val_q[ValWidth-2:0], 1'b0};
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntLast) begin
          state_d = BcdDone;
        end
      end
      BcdDone: begin
        state_d = BcdIdle;
      end
      default: begin
        state_d = BcdIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BcdIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q     <= bin_d;
    val_q     <= val_d;
    ctr_bcd_q <= ctr_bcd_d;
    val_bcd_q <= val_bcd_d;
  end

  always_comb begin
    result_o.busy       = (state_q != BcdIdle);
    result_o.wr         = (state_q == BcdDone);
    result_o.val_tens   = val_bcd_q[7:4];
    result_o.val_units  = val_bcd_q[3:0];
    result_o.ctr_digits = ctr_bcd_q;
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BcdShift |-> cnt_q <= CntLast)
    else $error("bcd step count out of range");

  a_done_after_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BcdDone |-> $past(state_q) == BcdShift && $past(cnt_q) == CntLast)
    else $error("bcd finished without a full run");

  a_digits_decimal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BcdDone |-> val_bcd_q[7:4] <= 4'd9 && ctr_bcd_q[23:20] <= 4'd9)
    else $error("bcd leading digit not decimal");

endmodule

### sv/mss_scan.sv
// ----------------------------------------------------------------------------
// mss_scan: digit store, scan slot and registered output word.
// Takes finished digits from the converter and drives one slot per tick.
// ----------------------------------------------------------------------------
module mss_scan (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 tick_i,
  input  mss_pkg::bcd_result_t load_i,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output mss_pkg::out_word_t   out_word_o
);
  import mss_pkg::*;

  logic [SlotCount-1:0][3:0] store_q, store_d;
  logic [SlotWidth-1:0]      slot_q, slot_d;
  logic                      out_valid_q, out_valid_d;
  out_word_t                 out_q, out_d;
  logic                      slot_is_last;

  assign slot_is_last = (slot_q == SLOT_LAST);

  always_comb begin
    store_d     = store_q;
    slot_d      = slot_q;
    out_d       = out_q;
    out_valid_d = out_valid_q & out_stall_i;
    if (load_i.wr) begin
      store_d[0] = load_i.val_units;
      store_d[1] = load_i.val_tens;
      store_d[2] = BLANK_CODE;
      for (int i = 0; i < CtrDigits; i++) begin
        store_d[i+3] = load_i.ctr_digits[i];
      end
    end
    if (tick_i) begin
      out_d.select_code     = slot_is_last ? 3'd0 : slot_q[2:0];
      out_d.high_bank       = slot_is_last;
      out_d.segment_pattern = seg_pattern(store_q[slot_q]);
      out_valid_d           = 1'b1;
      slot_d                = slot_is_last ? '0 : slot_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      store_q     <= {SlotCount{BLANK_CODE}};
      slot_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      store_q     <= store_d;
      slot_q      <= slot_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q <= SLOT_LAST)
    else $error("scan slot out of range");

  a_high_bank_select: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.high_bank |-> out_q.select_code == 3'd0)
    else $error("high bank with nonzero select code");

  a_no_tick_on_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i.wr |-> !tick_i)
    else $error("tick taken while store is written");

  a_tick_overwrites_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_i |-> !(out_valid_q && out_stall_i))
    else $error("tick would overwrite a waiting word");

endmodule
